// File: design/homogeneous_line_clip_project_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the line clip project
// Immediate-cycle and next-cycle implication checks on clk_i / rst_ni.
// ----------------------------------------------------------------------------
`ifndef HOMOGENEOUS_LINE_CLIP_PROJECT_MACROS_SVH
`define HOMOGENEOUS_LINE_CLIP_PROJECT_MACROS_SVH

// Check cons in the same cycle as ante.
`define HLC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define HLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/hlc_pkg.sv
// ----------------------------------------------------------------------------
// hlc_pkg
// Widths, types and plane code helper for the homogeneous line clipper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hlc_pkg;

  localparam int COORD_WIDTH    = 32;
  localparam int FRAC_BITS      = 16;
  localparam int SCALE_WIDTH    = 17;
  localparam int OFFSET_WIDTH   = 18;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = 32;
  localparam int NUM_PLANES     = 6;

  // clip divider: quotient never exceeds the coordinate difference
  localparam int DEN_WIDTH   = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
  localparam int CLIP_STEPS  = COORD_WIDTH;
  // projection divider: full quotient of scale * coord / w
  localparam int PROJ_WIDTH  = SCALE_WIDTH + COORD_WIDTH;
  localparam int PROJ_STEPS  = PROJ_WIDTH;

  localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = SCALE_WIDTH'(1) << FRAC_BITS;

  typedef logic [COORD_WIDTH-1:0] coord_t;
  // element 0 x, 1 y, 2 z, 3 w
  typedef logic [3:0][COORD_WIDTH-1:0] point_t;

  typedef struct packed {
    logic   vis;
    point_t p0;
    point_t p1;
  } seg_t;

  typedef enum logic [2:0] {
    PLANE_LEFT   = 3'd0,  // w + x
    PLANE_RIGHT  = 3'd1,  // w - x
    PLANE_BOTTOM = 3'd2,  // w + y
    PLANE_TOP    = 3'd3,  // w - y
    PLANE_NEAR   = 3'd4,  // w + z
    PLANE_FAR    = 3'd5   // w - z
  } plane_e;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_SCALE_X  = 3'd0,
    REG_SCALE_Y  = 3'd1,
    REG_OFFSET_X = 3'd2,
    REG_OFFSET_Y = 3'd3
  } cfg_reg_e;

  // Signed distance code of a point against one plane; negative is outside.
  function automatic logic signed [COORD_WIDTH:0] plane_code(point_t p, plane_e pl);
    logic signed [COORD_WIDTH:0] w;
    logic signed [COORD_WIDTH:0] c;
    logic                        minus;
    w = $signed({p[3][COORD_WIDTH-1], p[3]});
    unique case (pl)
      PLANE_LEFT, PLANE_RIGHT: c = $signed({p[0][COORD_WIDTH-1], p[0]});
      PLANE_BOTTOM, PLANE_TOP: c = $signed({p[1][COORD_WIDTH-1], p[1]});
      default:                 c = $signed({p[2][COORD_WIDTH-1], p[2]});
    endcase
    minus = (pl == PLANE_RIGHT) || (pl == PLANE_TOP) || (pl == PLANE_FAR);
    return minus ? (w - c) : (w + c);
  endfunction

endpackage

// File: design/hlc_clip_plane.sv
// ----------------------------------------------------------------------------
// hlc_clip_plane
// Clip one segment against one plane: code, select, multiply, divide, move.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hlc_clip_plane (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  hlc_pkg::plane_e plane_i,
  input  logic            valid_i,
  input  hlc_pkg::seg_t   seg_i,
  output logic            valid_o,
  output hlc_pkg::seg_t   seg_o
);
  import hlc_pkg::*;

  typedef struct packed {
    seg_t                        seg;
    logic                        mv0;
    logic                        mv1;
    logic [3:0]                  neg;
    logic [DEN_WIDTH-1:0]        den;
    logic [3:0][DEN_WIDTH-1:0]   rem;
    logic [3:0][COORD_WIDTH-1:0] rq;
  } div_t;

  // One restoring step per lane: next dividend bit comes from the top of rq,
  // quotient bit shifts in at the bottom.
  function automatic div_t div_step(div_t s);
    div_t                 r;
    logic [DEN_WIDTH:0]   t;
    logic                 qb;
    r = s;
    for (int k = 0; k < 4; k++) begin
      t  = {s.rem[k], s.rq[k][COORD_WIDTH-1]};
      qb = (t >= {1'b0, s.den});
      if (qb) begin
        r.rem[k] = DEN_WIDTH'(t - {1'b0, s.den});
      end else begin
        r.rem[k] = t[DEN_WIDTH-1:0];
      end
      r.rq[k] = {s.rq[k][COORD_WIDTH-2:0], qb};
    end
    return r;
  endfunction

  // stage 1: plane codes
  logic                        s1_valid_q;
  seg_t                        s1_seg_q;
  logic signed [COORD_WIDTH:0] s1_a_q, s1_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_seg_q <= seg_i;
      s1_a_q   <= plane_code(seg_i.p0, plane_i);
      s1_b_q   <= plane_code(seg_i.p1, plane_i);
    end
  end

  // stage 2: reject, pick the moving endpoint, denominator and differences
  logic                          rej, mv0, mv1;
  logic signed [COORD_WIDTH:0]   c_in, c_out;
  logic signed [COORD_WIDTH+1:0] den_full;
  logic [3:0][COORD_WIDTH:0]     diff_d;
  seg_t                          s2_seg_d;

  always_comb begin
    rej      = s1_a_q[COORD_WIDTH] & s1_b_q[COORD_WIDTH];
    mv0      = s1_a_q[COORD_WIDTH] & ~rej;
    mv1      = s1_b_q[COORD_WIDTH] & ~s1_a_q[COORD_WIDTH];
    c_in     = mv0 ? s1_b_q : s1_a_q;
    c_out    = mv0 ? s1_a_q : s1_b_q;
    den_full = $signed({c_in[COORD_WIDTH], c_in}) - $signed({c_out[COORD_WIDTH], c_out});
    for (int k = 0; k < 4; k++) begin
      if (mv0) begin
        diff_d[k] = {s1_seg_q.p0[k][COORD_WIDTH-1], s1_seg_q.p0[k]}
                  - {s1_seg_q.p1[k][COORD_WIDTH-1], s1_seg_q.p1[k]};
      end else begin
        diff_d[k] = {s1_seg_q.p1[k][COORD_WIDTH-1], s1_seg_q.p1[k]}
                  - {s1_seg_q.p0[k][COORD_WIDTH-1], s1_seg_q.p0[k]};
      end
    end
    s2_seg_d     = s1_seg_q;
    s2_seg_d.vis = s1_seg_q.vis & ~rej;
  end

  logic                      s2_valid_q, s2_mv0_q, s2_mv1_q;
  seg_t                      s2_seg_q;
  logic [COORD_WIDTH-1:0]    s2_cin_q;
  logic [DEN_WIDTH-1:0]      s2_den_q;
  logic [3:0][COORD_WIDTH:0] s2_diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_seg_q  <= s2_seg_d;
      s2_mv0_q  <= mv0;
      s2_mv1_q  <= mv1;
      s2_cin_q  <= c_in[COORD_WIDTH-1:0];
      s2_den_q  <= den_full[DEN_WIDTH-1:0];
      s2_diff_q <= diff_d;
    end
  end

  // stage 3: magnitudes of the differences
  logic                        s3_valid_q, s3_mv0_q, s3_mv1_q;
  seg_t                        s3_seg_q;
  logic [COORD_WIDTH-1:0]      s3_cin_q;
  logic [DEN_WIDTH-1:0]        s3_den_q;
  logic [3:0]                  s3_neg_q;
  logic [3:0][COORD_WIDTH-1:0] s3_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_seg_q <= s2_seg_q;
      s3_mv0_q <= s2_mv0_q;
      s3_mv1_q <= s2_mv1_q;
      s3_cin_q <= s2_cin_q;
      s3_den_q <= s2_den_q;
      for (int k = 0; k < 4; k++) begin
        s3_neg_q[k] <= s2_diff_q[k][COORD_WIDTH];
        s3_mag_q[k] <= s2_diff_q[k][COORD_WIDTH]
                     ? COORD_WIDTH'(~s2_diff_q[k] + 1'b1)
                     : s2_diff_q[k][COORD_WIDTH-1:0];
      end
    end
  end

  // stage 4 multiply, then one divide step per stage
  div_t                div_q [CLIP_STEPS+1];
  logic [CLIP_STEPS:0] div_valid_q;
  div_t                div_init;

  always_comb begin
    div_init.seg = s3_seg_q;
    div_init.mv0 = s3_mv0_q;
    div_init.mv1 = s3_mv1_q;
    div_init.neg = s3_neg_q;
    div_init.den = s3_den_q;
    for (int k = 0; k < 4; k++) begin
      {div_init.rem[k], div_init.rq[k]} =
        {1'b0, PROD_WIDTH'(s3_cin_q) * PROD_WIDTH'(s3_mag_q[k])};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_valid_q <= '0;
    end else if (en_i) begin
      div_valid_q <= {div_valid_q[CLIP_STEPS-1:0], s3_valid_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q[0] <= div_init;
      for (int j = 0; j < CLIP_STEPS; j++) begin
        div_q[j+1] <= div_step(div_q[j]);
      end
    end
  end

  // final stage: move the outside endpoint to pin +/- quotient
  seg_t                          fin_seg_d;
  logic [COORD_WIDTH-1:0]        pin;
  logic [COORD_WIDTH+1:0]        nv;

  always_comb begin
    fin_seg_d = div_q[CLIP_STEPS].seg;
    pin       = '0;
    nv        = '0;
    for (int k = 0; k < 4; k++) begin
      pin = div_q[CLIP_STEPS].mv0 ? div_q[CLIP_STEPS].seg.p1[k]
                                  : div_q[CLIP_STEPS].seg.p0[k];
      if (div_q[CLIP_STEPS].neg[k]) begin
        nv = {{2{pin[COORD_WIDTH-1]}}, pin} - {2'b00, div_q[CLIP_STEPS].rq[k]};
      end else begin
        nv = {{2{pin[COORD_WIDTH-1]}}, pin} + {2'b00, div_q[CLIP_STEPS].rq[k]};
      end
      if (div_q[CLIP_STEPS].seg.vis && div_q[CLIP_STEPS].mv0) begin
        fin_seg_d.p0[k] = nv[COORD_WIDTH-1:0];
      end
      if (div_q[CLIP_STEPS].seg.vis && div_q[CLIP_STEPS].mv1) begin
        fin_seg_d.p1[k] = nv[COORD_WIDTH-1:0];
      end
    end
  end

  logic fin_valid_q;
  seg_t fin_seg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (en_i) begin
      fin_valid_q <= div_valid_q[CLIP_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fin_seg_q <= fin_seg_d;
    end
  end

  assign valid_o = fin_valid_q;
  assign seg_o   = fin_seg_q;

endmodule

// File: design/homogeneous_line_clip_project.sv
// Throughput one segment per cycle while the two-entry output queue has room.
// Depth is set by six plane stages (a 32-step clip divider each)
//   and the 49-step projection divider.
// Reset clears all valid bits and the output queue; viewport scales return to 1.0, offsets to 0.
// ----------------------------------------------------------------------------
// homogeneous_line_clip_project
// Six-plane homogeneous line clipper with viewport projection, fully pipelined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "homogeneous_line_clip_project_macros.svh"

module homogeneous_line_clip_project (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [hlc_pkg::CFG_IDX_WIDTH-1:0]  cfg_index_i,
  input  logic [hlc_pkg::CFG_DATA_WIDTH-1:0] cfg_data_i,
  // segment input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  hlc_pkg::coord_t                    start_x_i,
  input  hlc_pkg::coord_t                    start_y_i,
  input  hlc_pkg::coord_t                    start_z_i,
  input  hlc_pkg::coord_t                    start_w_i,
  input  hlc_pkg::coord_t                    end_x_i,
  input  hlc_pkg::coord_t                    end_y_i,
  input  hlc_pkg::coord_t                    end_z_i,
  input  hlc_pkg::coord_t                    end_w_i,
  // result output channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               visible_o,
  output hlc_pkg::coord_t                    first_screen_x_o,
  output hlc_pkg::coord_t                    first_screen_y_o,
  output hlc_pkg::coord_t                    second_screen_x_o,
  output hlc_pkg::coord_t                    second_screen_y_o
);
  import hlc_pkg::*;

  localparam int SUM_WIDTH = PROJ_WIDTH + 2;
  localparam logic signed [SUM_WIDTH-1:0] SAT_HI =
    {{(SUM_WIDTH-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SAT_LO =
    {{(SUM_WIDTH-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic                        vis;
    logic [3:0]                  neg;
    coord_t                      w0;
    coord_t                      w1;
    logic [3:0][COORD_WIDTH-1:0] rem;
    logic [3:0][PROJ_WIDTH-1:0]  rq;
  } proj_t;

  // scr lanes: first x, first y, second x, second y
  typedef struct packed {
    logic   vis;
    point_t scr;
  } res_t;

  // Projection divide step; lanes 0/1 divide by the first w, 2/3 by the second.
  function automatic proj_t proj_step(proj_t s);
    proj_t                  r;
    logic [COORD_WIDTH:0]   t;
    logic [COORD_WIDTH-1:0] d;
    logic                   qb;
    r = s;
    for (int k = 0; k < 4; k++) begin
      d  = (k < 2) ? s.w0 : s.w1;
      t  = {s.rem[k], s.rq[k][PROJ_WIDTH-1]};
      qb = (t >= {1'b0, d});
      if (qb) begin
        r.rem[k] = COORD_WIDTH'(t - {1'b0, d});
      end else begin
        r.rem[k] = t[COORD_WIDTH-1:0];
      end
      r.rq[k] = {s.rq[k][PROJ_WIDTH-2:0], qb};
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Viewport registers. Writes to an index past the list are dropped.
  // ---------------------------------------------------------------------------
  logic [SCALE_WIDTH-1:0]  scale_x_q, scale_y_q;
  logic [OFFSET_WIDTH-1:0] offset_x_q, offset_y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q  <= SCALE_RESET;
      scale_y_q  <= SCALE_RESET;
      offset_x_q <= '0;
      offset_y_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SCALE_X:  scale_x_q  <= cfg_data_i[SCALE_WIDTH-1:0];
        REG_SCALE_Y:  scale_y_q  <= cfg_data_i[SCALE_WIDTH-1:0];
        REG_OFFSET_X: offset_x_q <= cfg_data_i[OFFSET_WIDTH-1:0];
        REG_OFFSET_Y: offset_y_q <= cfg_data_i[OFFSET_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Global advance. The whole pipeline moves together; it freezes only when
  // the two-entry output queue is full, so a result waiting on the consumer
  // does not stop new beats from entering.
  // ---------------------------------------------------------------------------
  logic [1:0] fifo_cnt_q;
  logic       pipe_en;
  logic       fifo_push, fifo_pop;

  assign pipe_en    = (fifo_cnt_q != 2'd2);
  assign in_ready_o = pipe_en;

  // ---------------------------------------------------------------------------
  // Entry stage: capture the beat and flag trivial rejection (both endpoints
  // outside the same plane).
  // ---------------------------------------------------------------------------
  seg_t in_seg_d;

  always_comb begin
    logic signed [COORD_WIDTH:0] ca;
    logic signed [COORD_WIDTH:0] cb;
    in_seg_d.p0  = {start_w_i, start_z_i, start_y_i, start_x_i};
    in_seg_d.p1  = {end_w_i, end_z_i, end_y_i, end_x_i};
    in_seg_d.vis = 1'b1;
    for (int i = 0; i < NUM_PLANES; i++) begin
      ca = plane_code(in_seg_d.p0, plane_e'(3'(i)));
      cb = plane_code(in_seg_d.p1, plane_e'(3'(i)));
      if (ca[COORD_WIDTH] && cb[COORD_WIDTH]) begin
        in_seg_d.vis = 1'b0;
      end
    end
  end

  logic in_valid_q;
  seg_t in_seg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (pipe_en) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      in_seg_q <= in_seg_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Plane chain, in order left, right, bottom, top, near, far. Each plane
  // recomputes codes on the points as earlier planes left them.
  // ---------------------------------------------------------------------------
  logic [NUM_PLANES:0] pl_valid;
  seg_t                pl_seg [NUM_PLANES+1];

  assign pl_valid[0] = in_valid_q;
  assign pl_seg[0]   = in_seg_q;

  for (genvar g = 0; g < NUM_PLANES; g++) begin : g_plane
    hlc_clip_plane u_plane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .plane_i (plane_e'(3'(g))),
      .valid_i (pl_valid[g]),
      .seg_i   (pl_seg[g]),
      .valid_o (pl_valid[g+1]),
      .seg_o   (pl_seg[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Projection T1: drop segments with w <= 0, split x/y into sign and magnitude.
  // ---------------------------------------------------------------------------
  logic                        t1_vis_d;
  logic [3:0][COORD_WIDTH-1:0] t1_c;
  logic [3:0][COORD_WIDTH-1:0] t1_mag_d;
  logic [3:0]                  t1_neg_d;

  always_comb begin
    t1_vis_d = pl_seg[NUM_PLANES].vis
             & ($signed(pl_seg[NUM_PLANES].p0[3]) > 0)
             & ($signed(pl_seg[NUM_PLANES].p1[3]) > 0);
    t1_c[0] = pl_seg[NUM_PLANES].p0[0];
    t1_c[1] = pl_seg[NUM_PLANES].p0[1];
    t1_c[2] = pl_seg[NUM_PLANES].p1[0];
    t1_c[3] = pl_seg[NUM_PLANES].p1[1];
    for (int k = 0; k < 4; k++) begin
      t1_neg_d[k] = t1_c[k][COORD_WIDTH-1];
      t1_mag_d[k] = t1_c[k][COORD_WIDTH-1] ? (~t1_c[k] + 1'b1) : t1_c[k];
    end
  end

  logic                        t1_valid_q, t1_vis_q;
  logic [3:0]                  t1_neg_q;
  logic [3:0][COORD_WIDTH-1:0] t1_mag_q;
  coord_t                      t1_w0_q, t1_w1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_valid_q <= 1'b0;
    end else if (pipe_en) begin
      t1_valid_q <= pl_valid[NUM_PLANES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      t1_vis_q <= t1_vis_d;
      t1_neg_q <= t1_neg_d;
      t1_mag_q <= t1_mag_d;
      t1_w0_q  <= pl_seg[NUM_PLANES].p0[3];
      t1_w1_q  <= pl_seg[NUM_PLANES].p1[3];
    end
  end

  // ---------------------------------------------------------------------------
  // Projection T2: scale * |coord|, then one divide step per stage by w.
  // ---------------------------------------------------------------------------
  proj_t               proj_init;
  proj_t               proj_q [PROJ_STEPS+1];
  logic [PROJ_STEPS:0] proj_valid_q;

  always_comb begin
    proj_init.vis = t1_vis_q;
    proj_init.neg = t1_neg_q;
    proj_init.w0  = t1_w0_q;
    proj_init.w1  = t1_w1_q;
    proj_init.rem = '0;
    for (int k = 0; k < 4; k++) begin
      proj_init.rq[k] = PROJ_WIDTH'((k % 2 == 0) ? scale_x_q : scale_y_q)
                      * PROJ_WIDTH'(t1_mag_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proj_valid_q <= '0;
    end else if (pipe_en) begin
      proj_valid_q <= {proj_valid_q[PROJ_STEPS-1:0], t1_valid_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      proj_q[0] <= proj_init;
      for (int j = 0; j < PROJ_STEPS; j++) begin
        proj_q[j+1] <= proj_step(proj_q[j]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Projection T3: restore the sign of the quotient.
  // ---------------------------------------------------------------------------
  logic                       t3_valid_q, t3_vis_q;
  logic [3:0][PROJ_WIDTH:0]   t3_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t3_valid_q <= 1'b0;
    end else if (pipe_en) begin
      t3_valid_q <= proj_valid_q[PROJ_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      t3_vis_q <= proj_q[PROJ_STEPS].vis;
      for (int k = 0; k < 4; k++) begin
        t3_val_q[k] <= proj_q[PROJ_STEPS].neg[k]
                     ? (~{1'b0, proj_q[PROJ_STEPS].rq[k]} + 1'b1)
                     : {1'b0, proj_q[PROJ_STEPS].rq[k]};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Projection T4: add the viewport offset, saturate, zero hidden segments.
  // The result goes straight into the output queue.
  // ---------------------------------------------------------------------------
  res_t                      res_d;
  logic signed [SUM_WIDTH-1:0] sum;

  always_comb begin
    res_d.vis = t3_vis_q;
    sum       = '0;
    for (int k = 0; k < 4; k++) begin
      sum = SUM_WIDTH'($signed(t3_val_q[k]))
          + SUM_WIDTH'($signed((k % 2 == 0) ? offset_x_q : offset_y_q));
      if (!t3_vis_q) begin
        res_d.scr[k] = '0;
      end else if (sum > SAT_HI) begin
        res_d.scr[k] = SAT_HI[COORD_WIDTH-1:0];
      end else if (sum < SAT_LO) begin
        res_d.scr[k] = SAT_LO[COORD_WIDTH-1:0];
      end else begin
        res_d.scr[k] = sum[COORD_WIDTH-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output queue: two entries, so the pipeline keeps moving while one result
  // waits for the consumer.
  // ---------------------------------------------------------------------------
  res_t fifo_q [2];
  logic wr_ptr_q, rd_ptr_q;
  res_t out_res;

  assign fifo_push = pipe_en & t3_valid_q;
  assign fifo_pop  = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_cnt_q <= '0;
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
    end else begin
      fifo_cnt_q <= fifo_cnt_q + {1'b0, fifo_push} - {1'b0, fifo_pop};
      if (fifo_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (fifo_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fifo_push) begin
      fifo_q[wr_ptr_q] <= res_d;
    end
  end

  assign out_res           = fifo_q[rd_ptr_q];
  assign out_valid_o       = (fifo_cnt_q != 2'd0);
  assign visible_o         = out_res.vis;
  assign first_screen_x_o  = out_res.scr[0];
  assign first_screen_y_o  = out_res.scr[1];
  assign second_screen_x_o = out_res.scr[2];
  assign second_screen_y_o = out_res.scr[3];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `HLC_ASSERT_NOW(a_hidden_zero, out_valid_o && !visible_o, (first_screen_x_o == '0) && (first_screen_y_o == '0) && (second_screen_x_o == '0) && (second_screen_y_o == '0), "hidden segment with nonzero screen point")
  `HLC_ASSERT_NEXT(a_cnt_grow, fifo_push && !fifo_pop, fifo_cnt_q == $past(fifo_cnt_q) + 2'd1, "output queue count lost a push")
  `HLC_ASSERT_NEXT(a_stall_hold, !pipe_en, $stable(proj_valid_q) && $stable(t3_valid_q), "pipeline moved while stalled")

endmodule

// File: verif/homogeneous_line_clip_project_tb.sv
// ----------------------------------------------------------------------------
// homogeneous_line_clip_project_tb
// Self-checking bench for the six-plane line clipper: a queue-fed driver
// pushes segment beats, a monitor checks every result beat against an
// in-bench clip and projection predictor, across several viewport settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module homogeneous_line_clip_project_tb;
  import hlc_pkg::*;

  localparam longint ONE      = 64'sd65536;  // 1.0 in Q16.16
  localparam int     WD_LIMIT = 20000;       // idle cycles before giving up
  localparam int     DRAIN    = 300;         // settle cycles, more than the pipeline depth

  typedef struct packed {
    coord_t sx, sy, sz, sw, ex, ey, ez, ew;
  } segment_t;

  typedef struct packed {
    logic   vis;
    coord_t fx, fy, sx, sy;
  } screen_t;

  typedef struct packed {
    logic [CFG_IDX_WIDTH-1:0]  idx;
    logic [CFG_DATA_WIDTH-1:0] data;
  } reg_write_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_WIDTH-1:0]  cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_data  = '0;

  logic     in_valid = 1'b0;
  logic     in_ready;
  segment_t seg_drv  = '0;

  logic     out_valid;
  logic     out_ready = 1'b0;
  logic     vis_o;
  coord_t   fx_o, fy_o, sx_o, sy_o;

  // pending beats, expected screen results, predictor's copy of the viewport
  segment_t   seg_q[$];
  reg_write_t reg_q[$];
  screen_t    screen_q[$];
  logic [SCALE_WIDTH-1:0]  vp_scale_x = SCALE_RESET, vp_scale_y = SCALE_RESET;
  logic [OFFSET_WIDTH-1:0] vp_off_x = '0, vp_off_y = '0;

  int send_idle = 0, recv_stall = 0;
  int n_errors = 0, n_checked = 0, n_visible = 0, n_regs = 0, idle_cnt = 0;

  homogeneous_line_clip_project dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .start_x_i        (seg_drv.sx),
    .start_y_i        (seg_drv.sy),
    .start_z_i        (seg_drv.sz),
    .start_w_i        (seg_drv.sw),
    .end_x_i          (seg_drv.ex),
    .end_y_i          (seg_drv.ey),
    .end_z_i          (seg_drv.ez),
    .end_w_i          (seg_drv.ew),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .visible_o        (vis_o),
    .first_screen_x_o (fx_o),
    .first_screen_y_o (fy_o),
    .second_screen_x_o(sx_o),
    .second_screen_y_o(sy_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // trunc(a * b / d) at 128 bits, clamped to the 64-bit signed range
  function automatic logic signed [127:0] mul_div_trunc(longint a, longint b, longint d);
    logic signed [127:0] aa, bb, dd, q;
    aa = a;
    bb = b;
    dd = d;
    q  = (aa * bb) / dd;
    if (q > 128'sh7FFF_FFFF_FFFF_FFFF) q = 128'sh7FFF_FFFF_FFFF_FFFF;
    if (q < -128'sh7FFF_FFFF_FFFF_FFFF) q = -128'sh7FFF_FFFF_FFFF_FFFF;
    return q;
  endfunction

  // distance code of a point against one plane; negative means outside
  function automatic longint plane_dist(longint pt[4], plane_e pl);
    longint c;
    case (pl)
      PLANE_LEFT, PLANE_RIGHT: c = pt[0];
      PLANE_BOTTOM, PLANE_TOP: c = pt[1];
      default:                 c = pt[2];
    endcase
    if (pl == PLANE_RIGHT || pl == PLANE_TOP || pl == PLANE_FAR) return pt[3] - c;
    return pt[3] + c;
  endfunction

  // slide the outside point onto the plane, rounding toward the inside point
  function automatic void slide_to_plane(inout longint pout[4], input longint pin[4],
                                         input longint cin, input longint cout);
    logic signed [127:0] q;
    for (int k = 0; k < 4; k++) begin
      q = mul_div_trunc(cin, pout[k] - pin[k], cin - cout);
      pout[k] = pin[k] + longint'(q);
    end
  endfunction

  function automatic coord_t to_screen(longint c, longint w, logic [SCALE_WIDTH-1:0] scale,
                                       logic [OFFSET_WIDTH-1:0] off);
    logic signed [127:0] v;
    longint              s;
    s = longint'({47'b0, scale});
    v = mul_div_trunc(s, c, w);
    v = v + $signed(off);
    if (v > 128'sh7FFF_FFFF) v = 128'sh7FFF_FFFF;
    if (v < -128'sh8000_0000) v = -128'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic screen_t clip_and_project(segment_t s);
    longint  a[4], b[4], ca, cb;
    logic    vis;
    screen_t r;
    a   = '{longint'($signed(s.sx)), longint'($signed(s.sy)),
            longint'($signed(s.sz)), longint'($signed(s.sw))};
    b   = '{longint'($signed(s.ex)), longint'($signed(s.ey)),
            longint'($signed(s.ez)), longint'($signed(s.ew))};
    vis = 1'b1;
    for (int i = 0; i < NUM_PLANES; i++)
      if (plane_dist(a, plane_e'(i)) < 0 && plane_dist(b, plane_e'(i)) < 0) vis = 1'b0;
    if (vis) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        ca = plane_dist(a, plane_e'(i));
        cb = plane_dist(b, plane_e'(i));
        if (ca < 0 && cb < 0) begin
          vis = 1'b0;
          break;
        end
        if (ca < 0) slide_to_plane(a, b, cb, ca);
        else if (cb < 0) slide_to_plane(b, a, ca, cb);
      end
    end
    if (vis && (a[3] <= 0 || b[3] <= 0)) vis = 1'b0;
    r = '0;
    r.vis = vis;
    if (vis) begin
      r.fx = to_screen(a[0], a[3], vp_scale_x, vp_off_x);
      r.fy = to_screen(a[1], a[3], vp_scale_y, vp_off_y);
      r.sx = to_screen(b[0], b[3], vp_scale_x, vp_off_x);
      r.sy = to_screen(b[1], b[3], vp_scale_y, vp_off_y);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic segment_t mk_seg(longint x0, longint y0, longint z0, longint w0,
                                      longint x1, longint y1, longint z1, longint w1);
    segment_t s;
    s = '{x0[31:0], y0[31:0], z0[31:0], w0[31:0], x1[31:0], y1[31:0], z1[31:0], w1[31:0]};
    return s;
  endfunction

  // coordinate within +/- span * w around zero
  function automatic longint near_coord(longint w, int span);
    return longint'($urandom_range(0, 2 * span * w)) - span * w;
  endfunction

  function automatic segment_t random_segment();
    segment_t s;
    longint   w0, w1;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      // well-formed: small positive w, points around the view volume
      w0 = $urandom_range(ONE / 4, 4 * ONE);
      w1 = $urandom_range(ONE / 4, 4 * ONE);
      s  = mk_seg(near_coord(w0, 2), near_coord(w0, 2), near_coord(w0, 2), w0,
                  near_coord(w1, 2), near_coord(w1, 2), near_coord(w1, 2), w1);
    end else if (pick < 75) begin
      // long segments with large w, crossing many planes
      w0 = $urandom_range(1, 32'h3FFF_FFFF);
      w1 = $urandom_range(1, 32'h3FFF_FFFF);
      s  = mk_seg(near_coord(w0, 1), near_coord(w0, 1), near_coord(w0, 1), w0,
                  near_coord(w1, 1), near_coord(w1, 1), near_coord(w1, 1), w1);
    end else if (pick < 90) begin
      s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      // w from -2 to 2 on one end, tiny on the other
      w0 = longint'($urandom_range(0, 4)) - 2;
      w1 = $urandom_range(1, 3);
      s  = mk_seg(near_coord(1, 1), near_coord(1, 1), near_coord(1, 1), w0,
                  near_coord(w1, 2), near_coord(w1, 2), near_coord(w1, 2), w1);
    end
    return s;
  endfunction

  function automatic reg_write_t reg_wr(cfg_reg_e idx, longint val);
    reg_write_t w;
    w.idx  = idx;
    w.data = val[31:0];
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: segment beats and register writes, both fed from queues
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (in_valid && in_ready) screen_q.push_back(clip_and_project(seg_drv));
    // free slot: take the next pending beat or idle
    if (!in_valid || in_ready) begin
      if (seg_q.size() > 0 && rst_ni && $urandom_range(99) >= send_idle) begin
        seg_drv  <= seg_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (cfg_valid && cfg_ready) begin
      n_regs++;
      case (cfg_index)
        REG_SCALE_X:  vp_scale_x = cfg_data[SCALE_WIDTH-1:0];
        REG_SCALE_Y:  vp_scale_y = cfg_data[SCALE_WIDTH-1:0];
        REG_OFFSET_X: vp_off_x   = cfg_data[OFFSET_WIDTH-1:0];
        REG_OFFSET_Y: vp_off_y   = cfg_data[OFFSET_WIDTH-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
    if (!cfg_valid || cfg_ready) begin
      if (reg_q.size() > 0 && rst_ni) begin
        {cfg_index, cfg_data} <= reg_q.pop_front();
        cfg_valid <= 1'b1;
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure, field-by-field compare against the oldest
  // --------------------------------------------------------------------------
  function automatic void check_field(string nm, coord_t want, coord_t got);
    if (want !== got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, nm,
               $signed(want), $signed(got));
    end
  endfunction

  always @(posedge clk_i) begin
    screen_t e;
    if (out_valid && out_ready) begin
      if (screen_q.size() == 0) begin
        n_errors++;
        $display("%0t: result beat with nothing expected, visible %0b", $time, vis_o);
      end else begin
        e = screen_q.pop_front();
        n_checked++;
        if (e.vis) n_visible++;
        if (e.vis !== vis_o) begin
          n_errors++;
          $display("%0t: visible mismatch, expected %0b actual %0b", $time, e.vis, vis_o);
        end
        check_field("first_screen_x", e.fx, fx_o);
        check_field("first_screen_y", e.fy, fy_o);
        check_field("second_screen_x", e.sx, sx_o);
        check_field("second_screen_y", e.sy, sy_o);
      end
    end
    out_ready <= rst_ni && ($urandom_range(99) >= recv_stall);
  end

  // watchdog: any handshake on any channel counts as progress
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WD_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, WD_LIMIT, screen_q.size());
      $display("** homogeneous_line_clip_project: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------

  // hold until every queued beat is sent, every result is back, then let the
  // pipeline settle before the viewport changes
  task automatic drain();
    wait (seg_q.size() == 0 && reg_q.size() == 0 && !in_valid && !cfg_valid);
    wait (screen_q.size() == 0);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic run_phase(int idle_in, int stall_out, int count);
    send_idle  = idle_in;
    recv_stall = stall_out;
    for (int i = 0; i < count; i++) seg_q.push_back(random_segment());
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed segments under the reset viewport
    seg_q.push_back(mk_seg(0, 0, 0, ONE, ONE / 2, -ONE / 2, ONE / 4, ONE));  // inside
    seg_q.push_back(mk_seg(0, 0, 0, 0, 0, 0, 0, 0));                         // w zero
    seg_q.push_back(mk_seg(-2 * ONE, 0, 0, ONE, 0, 0, 0, ONE));              // left
    seg_q.push_back(mk_seg(2 * ONE, 0, 0, ONE, 0, 0, 0, ONE));               // right
    seg_q.push_back(mk_seg(0, -2 * ONE, 0, ONE, 0, 0, 0, ONE));              // bottom
    seg_q.push_back(mk_seg(0, 0, 0, ONE, 0, 3 * ONE, 0, ONE));               // top
    seg_q.push_back(mk_seg(0, 0, -2 * ONE, ONE, 0, 0, 0, ONE));              // near
    seg_q.push_back(mk_seg(0, 0, 0, ONE, 0, 0, 5 * ONE, 2 * ONE));           // far
    seg_q.push_back(mk_seg(2 * ONE, 0, 0, ONE, 3 * ONE, 0, 0, ONE));         // both out
    seg_q.push_back(mk_seg(-3 * ONE, 2 * ONE, 0, ONE, 3 * ONE, -2 * ONE, 0, ONE));
    // outside a later plane once the first clip has moved an end
    seg_q.push_back(mk_seg(2 * ONE, 3 * ONE / 2, 0, ONE, -2 * ONE, 58982, 0, ONE));
    seg_q.push_back(mk_seg(-2 * ONE, 58982, 0, ONE, 2 * ONE, 3 * ONE / 2, 0, ONE));
    seg_q.push_back(mk_seg(0, 0, 0, -ONE, 0, 0, 0, ONE));                    // w negative
    seg_q.push_back(mk_seg(0, 0, 0, 1, 0, 0, 0, 1));                         // tiny w
    seg_q.push_back(mk_seg(0, 0, 0, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, -64'sh7FFF_FFFF,
                           64'sh7FFF_FFFF, 64'sh7FFF_FFFF));
    seg_q.push_back(mk_seg(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000,
                           -64'sh8000_0000, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF,
                           64'sh7FFF_FFFF, 64'sh7FFF_FFFF));
    seg_q.push_back(mk_seg(-64'sh7FFF_FFFF, 0, 0, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 0, 0,
                           64'sh7FFF_FFFF));
    seg_q.push_back(mk_seg(1, 1, 1, 1, -1, -1, -1, 1));
    seg_q.push_back({8{32'hFFFF_FFFF}});
    seg_q.push_back({8{32'h5555_5555}});
    run_phase(0, 0, 360);

    // unit scale, offsets at +1.0
    reg_q.push_back(reg_wr(REG_SCALE_X, ONE));
    reg_q.push_back(reg_wr(REG_SCALE_Y, ONE));
    reg_q.push_back(reg_wr(REG_OFFSET_X, ONE));
    reg_q.push_back(reg_wr(REG_OFFSET_Y, ONE));
    drain();
    run_phase(74, 0, 360);

    // collapsed viewport, offsets at -1.0
    reg_q.push_back(reg_wr(REG_SCALE_X, 0));
    reg_q.push_back(reg_wr(REG_SCALE_Y, 0));
    reg_q.push_back(reg_wr(REG_OFFSET_X, -ONE));
    reg_q.push_back(reg_wr(REG_OFFSET_Y, -ONE));
    drain();
    run_phase(0, 74, 360);

    // random viewport, with writes to indexes past the register map
    reg_q.push_back(reg_wr(REG_SCALE_X, $urandom_range(0, ONE)));
    reg_q.push_back(reg_wr(REG_SCALE_Y, $urandom_range(0, ONE)));
    reg_q.push_back(reg_wr(REG_OFFSET_X, longint'($urandom_range(0, 2 * ONE)) - ONE));
    reg_q.push_back(reg_wr(REG_OFFSET_Y, longint'($urandom_range(0, 2 * ONE)) - ONE));
    for (int i = 4; i < 8; i++) reg_q.push_back('{CFG_IDX_WIDTH'(i), $urandom});
    drain();
    run_phase(36, 36, 360);

    reg_q.push_back(reg_wr(REG_SCALE_X, $urandom_range(ONE / 2, ONE)));
    reg_q.push_back(reg_wr(REG_SCALE_Y, $urandom_range(1, ONE / 2)));
    reg_q.push_back(reg_wr(REG_OFFSET_X, longint'($urandom_range(0, 2 * ONE)) - ONE));
    reg_q.push_back(reg_wr(REG_OFFSET_Y, longint'($urandom_range(0, 2 * ONE)) - ONE));
    drain();
    run_phase(0, 0, 360);

    $display("Checked %0d segments (%0d visible) over five viewport settings,", n_checked,
             n_visible);
    $display("%0d register writes, idle and stall phases on both channels.", n_regs);
    if (n_errors == 0 && screen_q.size() == 0) begin
      $display("** homogeneous_line_clip_project: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, screen_q.size());
      $display("** homogeneous_line_clip_project: FAILED **");
    end
    $finish;
  end

endmodule
